>>> src/fmru_pkg.sv
// package for the focus order mru list
// holds operation codes and the per-cell control struct; no dependencies
`default_nettype none
package fmru_pkg;

  localparam logic [1:0] OP_OPEN   = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct packed {
    logic open_go;
    logic close_go;
    logic switch_go;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> src/fmru_cell.sv
// one list cell: holds one identifier, compares it with the key and
// shifts to or from its neighbors; depends on fmru_pkg
`default_nettype none
module fmru_cell #(
  parameter int ID_WIDTH = 16
) (
  input  wire                     clk,
  input  wire fmru_pkg::cell_ctl_t ctl,
  input  wire  [ID_WIDTH-1:0]     key,
  input  wire  [ID_WIDTH-1:0]     left_id,
  input  wire  [ID_WIDTH-1:0]     right_id,
  input  wire                     occupied,
  input  wire                     hit_in,
  input  wire                     any_hit,
  output logic [ID_WIDTH-1:0]     id_out,
  output logic [ID_WIDTH-1:0]     id_next,
  output logic                    hit_out
);
  import fmru_pkg::*;

  logic [ID_WIDTH-1:0] id_q;
  logic                hit_here;

  assign hit_here = occupied && (id_q == key);
  assign hit_out  = hit_in | hit_here;
  assign id_out   = id_q;

  always_comb begin
    id_next = id_q;
    if (ctl.open_go) begin
      id_next = left_id;
    end else if (ctl.close_go && hit_out) begin
      id_next = right_id;
    end else if (ctl.switch_go && any_hit && !hit_in) begin
      id_next = left_id;
    end
  end

  always_ff @(posedge clk) begin
    id_q <= id_next;
  end

endmodule
`default_nettype wire

>>> src/focus_order_mru_list.sv
// top level of the focus order mru list: chain of fmru_cell plus count
// and registered result beat; depends on fmru_pkg and fmru_cell
//
// Move-to-front list of up to LIST_DEPTH window identifiers, front entry
// first. Every cell compares its identifier with the beat's window_id at
// once and shifts one place toward or away from the front, so a beat is
// applied on acceptance and its result beat appears on the output register
// the cycle after it is accepted. One beat is accepted per cycle; in_stall
// rises only while a result waits on a stalled output. The longest path is
// the first-match chain that runs through all LIST_DEPTH cells.
`default_nettype none
module focus_order_mru_list #(
  parameter int LIST_DEPTH = 16,
  parameter int ID_WIDTH   = 16,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [1:0]           operation,
  input  wire  [ID_WIDTH-1:0]  window_id,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [ID_WIDTH-1:0]  focus_id,
  output logic                 focus_valid,
  output logic                 open_refused,
  output logic [CNT_W-1:0]     entry_count
);
  import fmru_pkg::*;

  logic [CNT_W-1:0]    held_count;
  logic [CNT_W-1:0]    held_count_next;
  logic                accept;
  logic                full;
  logic                is_open;
  logic                is_close;
  logic                is_switch;
  cell_ctl_t           ctl;
  logic [ID_WIDTH-1:0] ids      [LIST_DEPTH];
  logic [ID_WIDTH-1:0] ids_next [LIST_DEPTH];
  logic [LIST_DEPTH:0] hit_chain;
  logic                any_hit;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (held_count == CNT_W'(LIST_DEPTH));

  always_comb begin
    is_open   = 1'b0;
    is_close  = 1'b0;
    is_switch = 1'b0;
    case (operation)
      OP_OPEN:   is_open   = 1'b1;
      OP_CLOSE:  is_close  = 1'b1;
      OP_SWITCH: is_switch = 1'b1;
      OP_NOP:    ;
      default:   ;
    endcase
  end

  always_comb begin
    ctl.open_go   = accept && is_open && !full;
    ctl.close_go  = accept && is_close;
    ctl.switch_go = accept && is_switch;
  end

  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[LIST_DEPTH];

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [ID_WIDTH-1:0] left_id;
    logic [ID_WIDTH-1:0] right_id;
    logic                occupied;

    if (k == 0) begin : g_first
      assign left_id = window_id;
    end else begin : g_mid
      assign left_id = ids[k-1];
    end
    if (k == LIST_DEPTH - 1) begin : g_last
      assign right_id = ids[k];
    end else begin : g_inner
      assign right_id = ids[k+1];
    end
    assign occupied = (CNT_W'(k) < held_count);

    fmru_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (window_id),
      .left_id  (left_id),
      .right_id (right_id),
      .occupied (occupied),
      .hit_in   (hit_chain[k]),
      .any_hit  (any_hit),
      .id_out   (ids[k]),
      .id_next  (ids_next[k]),
      .hit_out  (hit_chain[k+1])
    );
  end

  always_comb begin
    held_count_next = held_count;
    if (ctl.open_go) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (ctl.close_go && any_hit) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      focus_id     <= (held_count_next != '0) ? ids_next[0] : '0;
      focus_valid  <= (held_count_next != '0);
      open_refused <= is_open && full;
      entry_count  <= held_count_next;
    end
  end

endmodule
`default_nettype wire

>>> src/fmru_checker.sv
// port-level checks for focus_order_mru_list and the bind that attaches them
// depends on focus_order_mru_list ports only
`default_nettype none
module fmru_checker #(
  parameter int LIST_DEPTH = 16,
  parameter int ID_WIDTH   = 16,
  parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire [1:0]           operation,
  input wire [ID_WIDTH-1:0]  window_id,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire [ID_WIDTH-1:0]  focus_id,
  input wire                 focus_valid,
  input wire                 open_refused,
  input wire [CNT_W-1:0]     entry_count
);

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (focus_valid == (entry_count != '0)))
    else $error("focus_valid disagrees with entry_count");

  a_empty_focus: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !focus_valid) |-> (focus_id == '0))
    else $error("empty list shows nonzero focus");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && open_refused) |-> (entry_count == CNT_W'(LIST_DEPTH)))
    else $error("open refused on a list that is not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CNT_W'(LIST_DEPTH)))
    else $error("entry_count beyond depth");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(focus_id) &&
                                  $stable(entry_count)))
    else $error("stalled result beat changed");

endmodule

bind focus_order_mru_list fmru_checker #(
  .LIST_DEPTH (LIST_DEPTH),
  .ID_WIDTH   (ID_WIDTH),
  .CNT_W      (CNT_W)
) u_fmru_checker (.*);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// testbench for focus_order_mru_list: directed and random open, close and switch beats
// checked against an in-bench move-to-front list; depends on fmru_pkg and the rtl top
module tb;
  import fmru_pkg::*;

  localparam int DEPTH = 16;
  localparam int ID_W  = 16;
  localparam int CNT_W = 5;

  typedef struct packed {
    logic [ID_W-1:0]  focus_id;
    logic             focus_valid;
    logic             open_refused;
    logic [CNT_W-1:0] entry_count;
  } focus_result_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       operation;
  logic [ID_W-1:0]  window_id;
  logic             out_valid;
  logic             out_stall;
  logic [ID_W-1:0]  focus_id;
  logic             focus_valid;
  logic             open_refused;
  logic [CNT_W-1:0] entry_count;

  logic [ID_W-1:0]  list_ids [DEPTH];
  int               list_held;
  focus_result_t    expected_focus [$];

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int shown_count;
  int beats_sent;
  int directed_beats;
  int refused_opens;
  int full_beats;

  logic [ID_W-1:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
                                   16'h0001, 16'h8000, 16'h1234, 16'hFEDC};

  focus_order_mru_list #(
    .LIST_DEPTH(DEPTH),
    .ID_WIDTH  (ID_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .window_id   (window_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .focus_id    (focus_id),
    .focus_valid (focus_valid),
    .open_refused(open_refused),
    .entry_count (entry_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #4_000_000;
    $display("FAIL focus_order_mru_list");
    $finish;
  end

  // apply one beat to the local list and queue the result it should give
  task automatic predict_focus(input logic [1:0] op, input logic [ID_W-1:0] id);
    focus_result_t res;
    int pos;
    logic refused;
    refused = 1'b0;
    pos = list_held;
    if (list_held == DEPTH) full_beats++;
    for (int i = list_held - 1; i >= 0; i--)
      if (list_ids[i] == id) pos = i;
    case (op)
      OP_OPEN: begin
        if (list_held >= DEPTH) begin
          refused = 1'b1;
          refused_opens++;
        end else begin
          for (int k = list_held; k > 0; k--) list_ids[k] = list_ids[k-1];
          list_ids[0] = id;
          list_held++;
        end
      end
      OP_CLOSE: begin
        if (pos < list_held) begin
          for (int k = pos; k < list_held - 1; k++) list_ids[k] = list_ids[k+1];
          list_held--;
        end
      end
      OP_SWITCH: begin
        if (pos < list_held && pos > 0) begin
          for (int k = pos; k > 0; k--) list_ids[k] = list_ids[k-1];
          list_ids[0] = id;
        end
      end
      default: ;
    endcase
    res.focus_id     = (list_held > 0) ? list_ids[0] : '0;
    res.focus_valid  = (list_held > 0);
    res.open_refused = refused;
    res.entry_count  = list_held[CNT_W-1:0];
    expected_focus.push_back(res);
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    window_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_focus(op, id);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic note_failure(input string what, input focus_result_t want,
                              input focus_result_t got);
    err_count++;
    if (shown_count < 10) begin
      shown_count++;
      $display("%t %s: expected id %h valid %b refused %b count %0d",
               $realtime, what, want.focus_id, want.focus_valid, want.open_refused,
               want.entry_count);
      $display("%t %s: got      id %h valid %b refused %b count %0d",
               $realtime, what, got.focus_id, got.focus_valid, got.open_refused,
               got.entry_count);
    end
  endtask

  always @(posedge clk) begin : check_result
    focus_result_t want;
    focus_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{focus_id, focus_valid, open_refused, entry_count};
      if (expected_focus.size() == 0) begin
        note_failure("unexpected result beat", '0, got);
      end else begin
        want = expected_focus.pop_front();
        if (got !== want) note_failure("result mismatch", want, got);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_empty_list();
    send_beat(OP_CLOSE, 16'h0000);
    send_beat(OP_SWITCH, 16'h0000);
    send_beat(OP_NOP, 16'hFFFF);
  endtask

  task automatic test_open_switch_close();
    send_beat(OP_OPEN, 16'h0000);
    send_beat(OP_OPEN, 16'hFFFF);
    send_beat(OP_SWITCH, 16'hFFFF);
    send_beat(OP_SWITCH, 16'h0000);
    send_beat(OP_OPEN, 16'hFFFF);
    send_beat(OP_CLOSE, 16'hFFFF);
    send_beat(OP_CLOSE, 16'h1234);
    send_beat(OP_NOP, 16'h0000);
  endtask

  task automatic test_fill_and_refuse();
    while (list_held < DEPTH) send_beat(OP_OPEN, ID_W'(16'h1000 + list_held));
    send_beat(OP_OPEN, 16'hBEEF);
    send_beat(OP_SWITCH, list_ids[DEPTH-1]);
    send_beat(OP_CLOSE, list_ids[DEPTH-1]);
    send_beat(OP_OPEN, 16'hC0DE);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (list_held > 0 && r < 65) return list_ids[$urandom_range(list_held - 1)];
    if (r < 85) return id_pool[$urandom_range(7)];
    return ID_W'($urandom);
  endfunction

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int beats);
    int open_pct;
    int r;
    logic [1:0] op;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    open_pct = 50;
    for (int n = 0; n < beats; n++) begin
      if (n % 64 == 0) begin
        r = $urandom_range(2);
        open_pct = (r == 0) ? 25 : (r == 1) ? 50 : 85;
      end
      if ($urandom_range(99) < open_pct) begin
        op = OP_OPEN;
      end else begin
        r = $urandom_range(99);
        op = (r < 40) ? OP_CLOSE : (r < 88) ? OP_SWITCH : OP_NOP;
      end
      send_beat(op, pick_id());
    end
  endtask

  initial begin
    int waited;
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = OP_NOP;
    window_id      = '0;
    send_idle_pct  = 13;
    recv_stall_pct = 56;
    list_held      = 0;
    err_count      = 0;
    shown_count    = 0;
    beats_sent     = 0;
    refused_opens  = 0;
    full_beats     = 0;
    foreach (list_ids[i]) list_ids[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_list();
    test_open_switch_close();
    test_fill_and_refuse();
    directed_beats = beats_sent;
    test_random_traffic(13, 56, 320);
    test_random_traffic(56, 13, 320);
    test_random_traffic(0, 0, 310);
    in_valid <= 1'b0;

    waited = 0;
    while (expected_focus.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_focus.size() != 0) begin
      err_count++;
      $display("%0d expected result beats never arrived", expected_focus.size());
    end

    $display("sent %0d beats (%0d directed) under three idle/stall mixes, %0d mismatches",
             beats_sent, directed_beats, err_count);
    $display("%0d beats met a full list, %0d opens refused", full_beats, refused_opens);
    if (err_count == 0)
      $display("PASS focus_order_mru_list");
    else
      $display("FAIL focus_order_mru_list");
    $finish;
  end
endmodule
